// ----- src/bra_pkg.sv -----
// ----------------------------------------------------------------------------
// bra_pkg
// Shared types and constants for the block run allocator.
// ----------------------------------------------------------------------------
package bra_pkg;

  localparam int BLOCKS      = 256;
  localparam int BLOCK_BYTES = 32;
  localparam int WORD_W      = 8;                  // used marks per memory word
  localparam int WORDS       = BLOCKS / WORD_W;
  localparam int BADDR_W     = $clog2(BLOCKS);
  localparam int WADDR_W     = $clog2(WORDS);
  localparam int BIT_W       = $clog2(WORD_W);
  localparam int LEN_W       = 9;
  localparam int SIZE_W      = 16;
  localparam int NEED_W      = SIZE_W + 1;
  localparam int OFFSET_W    = 13;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef struct packed {
    logic              func;
    logic [SIZE_W-1:0] size;
    logic [7:0]        block_index;
  } req_t;

  typedef struct packed {
    logic                ok;
    logic [7:0]          start_block;
    logic [OFFSET_W-1:0] byte_offset;
    logic [LEN_W-1:0]    blocks_taken;
  } rsp_t;

  typedef struct packed {
    logic               en;
    logic [WADDR_W-1:0] addr;
    logic [WORD_W-1:0]  data;
  } used_wr_t;

  typedef struct packed {
    logic               en;
    logic [BADDR_W-1:0] addr;
    logic [LEN_W-1:0]   data;
  } len_wr_t;

endpackage

// ----- src/block_run_allocator.sv -----
// ----------------------------------------------------------------------------
// block_run_allocator
// First-fit allocator over a pool of equal-size blocks; allocate and free.
// ----------------------------------------------------------------------------
//  channel  ports                     handshake
//  input    start, busy, in_req       taken when start & !busy
//  result   out_strobe, out_rsp       one strobe per request, no backpressure
//
//  Allocate: issue, scan 8-block words in order until the run is found, then
//  mark each word of the run by read-modify-write. Free: fetch the run length,
//  then clear each word of the run by read-modify-write. A zero or oversize
//  allocate, a free of a non-start block and a search that finds no run end
//  with ok low. After reset a clearing pass zeroes both memories; busy stays
//  high during it. Result appears the cycle after the last write.
// ----------------------------------------------------------------------------
module block_run_allocator (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  bra_pkg::req_t in_req,
  output logic          out_strobe,
  output bra_pkg::rsp_t out_rsp
);
  import bra_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_FETCH, S_RMW_RD, S_RMW_WR
  } state_t;

  state_t             state_r, state_nxt;
  logic [BADDR_W-1:0] clr_r, clr_nxt;
  logic               func_r, func_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [LEN_W-1:0]   cnt_r, cnt_nxt;
  logic [WADDR_W-1:0] scan_w_r, scan_w_nxt;
  logic [WADDR_W-1:0] ptr_r, ptr_nxt;
  logic [BADDR_W-1:0] lo_r, lo_nxt;
  logic [BADDR_W-1:0] hi_r, hi_nxt;
  logic               out_strobe_r, out_strobe_nxt;
  rsp_t               out_rsp_r, out_rsp_nxt;

  used_wr_t           used_wr;
  logic [WADDR_W-1:0] used_rd_addr;
  logic [WORD_W-1:0]  used_rd;
  len_wr_t            len_wr;
  logic [BADDR_W-1:0] len_rd_addr;
  logic [LEN_W-1:0]   len_rd;

  logic [NEED_W-1:0]  need;
  logic [LEN_W-1:0]   scan_cnt;
  logic               scan_hit;
  logic [BIT_W-1:0]   scan_bit;
  logic [BADDR_W:0]   hit_blk;
  logic [BADDR_W:0]   free_end;
  logic [WORD_W-1:0]  mask;
  logic [BADDR_W-1:0] blk;

  bra_used_mem u_used (
    .clk     (clk),
    .wr      (used_wr),
    .rd_addr (used_rd_addr),
    .rd_data (used_rd)
  );

  bra_len_mem u_len (
    .clk     (clk),
    .wr      (len_wr),
    .rd_addr (len_rd_addr),
    .rd_data (len_rd)
  );

  assign need = ({1'b0, in_req.size} + NEED_W'(BLOCK_BYTES - 1)) / NEED_W'(BLOCK_BYTES);

  // run count across the word just read; stop at the first bit that fills it
  always_comb begin
    scan_cnt = cnt_r;
    scan_hit = 1'b0;
    scan_bit = '0;
    for (int b = 0; b < WORD_W; b++) begin
      if (!scan_hit) begin
        if (used_rd[b]) begin
          scan_cnt = '0;
        end else begin
          scan_cnt = scan_cnt + LEN_W'(1);
        end
        if (scan_cnt == len_r) begin
          scan_hit = 1'b1;
          scan_bit = BIT_W'(b);
        end
      end
    end
  end

  assign hit_blk  = {1'b0, scan_w_r, scan_bit} + (BADDR_W+1)'(1) - len_r;
  assign free_end = {1'b0, lo_r} + len_rd - (BADDR_W+1)'(1);

  // blocks of the current word that fall inside the run
  always_comb begin
    mask = '0;
    blk  = '0;
    for (int b = 0; b < WORD_W; b++) begin
      blk     = {ptr_r, BIT_W'(b)};
      mask[b] = (blk >= lo_r) && (blk <= hi_r);
    end
  end

  always_comb begin
    used_rd_addr = '0;
    len_rd_addr  = in_req.block_index;
    unique case (state_r)
      S_SCAN:   used_rd_addr = scan_w_r + WADDR_W'(1);
      S_RMW_RD: used_rd_addr = ptr_r;
      default:  used_rd_addr = '0;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    func_nxt       = func_r;
    len_nxt        = len_r;
    cnt_nxt        = cnt_r;
    scan_w_nxt     = scan_w_r;
    ptr_nxt        = ptr_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    out_strobe_nxt = 1'b0;
    out_rsp_nxt    = out_rsp_r;
    used_wr        = '0;
    len_wr         = '0;

    unique case (state_r)
      S_CLEAR: begin
        used_wr.en   = 1'b1;
        used_wr.addr = clr_r[BADDR_W-1:BIT_W];
        len_wr.en    = 1'b1;
        len_wr.addr  = clr_r;
        clr_nxt      = clr_r + BADDR_W'(1);
        if (clr_r == BADDR_W'(BLOCKS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          func_nxt = in_req.func;
          if (in_req.func == FUNC_ALLOC) begin
            if (need == '0 || need > NEED_W'(BLOCKS)) begin
              out_strobe_nxt = 1'b1;
              out_rsp_nxt    = '0;
            end else begin
              len_nxt    = LEN_W'(need);
              cnt_nxt    = '0;
              scan_w_nxt = '0;
              state_nxt  = S_SCAN;
            end
          end else begin
            lo_nxt = in_req.block_index;
            if ({1'b0, in_req.block_index} >= (BADDR_W+1)'(BLOCKS)) begin
              out_strobe_nxt = 1'b1;
              out_rsp_nxt    = '0;
            end else begin
              state_nxt = S_FETCH;
            end
          end
        end
      end

      S_SCAN: begin
        if (scan_hit) begin
          lo_nxt    = hit_blk[BADDR_W-1:0];
          hi_nxt    = {scan_w_r, scan_bit};
          ptr_nxt   = hit_blk[BADDR_W-1:BIT_W];
          state_nxt = S_RMW_RD;
        end else if (scan_w_r == WADDR_W'(WORDS - 1)) begin
          out_strobe_nxt = 1'b1;
          out_rsp_nxt    = '0;
          state_nxt      = S_IDLE;
        end else begin
          cnt_nxt    = scan_cnt;
          scan_w_nxt = scan_w_r + WADDR_W'(1);
        end
      end

      S_FETCH: begin
        if (len_rd == '0) begin
          out_strobe_nxt = 1'b1;
          out_rsp_nxt    = '0;
          state_nxt      = S_IDLE;
        end else begin
          len_nxt   = len_rd;
          // a run never passes the last block
          hi_nxt    = free_end[BADDR_W] ? BADDR_W'(BLOCKS - 1) : free_end[BADDR_W-1:0];
          ptr_nxt   = lo_r[BADDR_W-1:BIT_W];
          state_nxt = S_RMW_RD;
        end
      end

      S_RMW_RD: begin
        state_nxt = S_RMW_WR;
      end

      S_RMW_WR: begin
        used_wr.en   = 1'b1;
        used_wr.addr = ptr_r;
        used_wr.data = (func_r == FUNC_FREE) ? (used_rd & ~mask) : (used_rd | mask);
        if (ptr_r == hi_r[BADDR_W-1:BIT_W]) begin
          len_wr.en                = 1'b1;
          len_wr.addr              = lo_r;
          len_wr.data              = (func_r == FUNC_FREE) ? '0 : len_r;
          out_strobe_nxt           = 1'b1;
          out_rsp_nxt.ok           = 1'b1;
          out_rsp_nxt.start_block  = lo_r;
          out_rsp_nxt.byte_offset  = OFFSET_W'(32'(lo_r) * BLOCK_BYTES);
          out_rsp_nxt.blocks_taken = len_r;
          state_nxt                = S_IDLE;
        end else begin
          ptr_nxt   = ptr_r + WADDR_W'(1);
          state_nxt = S_RMW_RD;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    func_r    <= func_nxt;
    len_r     <= len_nxt;
    cnt_r     <= cnt_nxt;
    scan_w_r  <= scan_w_nxt;
    ptr_r     <= ptr_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_rsp    = out_rsp_r;

endmodule

// ----- src/bra_used_mem.sv -----
// ----------------------------------------------------------------------------
// bra_used_mem
// Used-mark bitmap, one bit per block, packed into words. One write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module bra_used_mem (
  input  logic                          clk,
  input  bra_pkg::used_wr_t             wr,
  input  logic [bra_pkg::WADDR_W-1:0]   rd_addr,
  output logic [bra_pkg::WORD_W-1:0]    rd_data
);
  import bra_pkg::*;

  logic [WORD_W-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- src/bra_len_mem.sv -----
// ----------------------------------------------------------------------------
// bra_len_mem
// Run length store, one entry per block, nonzero only at the first block of
// a live run. One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bra_len_mem (
  input  logic                          clk,
  input  bra_pkg::len_wr_t              wr,
  input  logic [bra_pkg::BADDR_W-1:0]   rd_addr,
  output logic [bra_pkg::LEN_W-1:0]     rd_data
);
  import bra_pkg::*;

  logic [LEN_W-1:0] mem [BLOCKS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
